@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL.
// Each macro expects signals named clk and rst in the calling scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset
`define ASSERT_CLK(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Implication checked at every clock edge out of reset
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/wsl_pkg.sv @@
// ----------------------------------------------------------------------------
// wsl_pkg
// Shared constants and register codes of the waypoint step limiter.
// ----------------------------------------------------------------------------
`default_nettype none

package wsl_pkg;

  // default geometry
  localparam int COORD_WIDTH_DEF = 24;
  localparam int FRAC_BITS_DEF   = 12;

  // configuration register width and index width
  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 2;

  // reset values: step 2.0 m, arrival radius 0.2 m (2/10)
  localparam int RESET_STEP_M      = 2;
  localparam int RESET_RADIUS_NUM  = 2;
  localparam int RESET_RADIUS_DEN  = 10;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_LENGTH    = 2'd0,
    REG_ARRIVAL_RADIUS = 2'd1
  } cfg_reg_t;

endpackage

`default_nettype wire

@@ rtl/core/waypoint_step_limiter.sv @@
// Throughput: one item per cycle while busy is low; the pipeline never stalls.
// Latency is set by the bit-per-stage square root and the 20-stage divider.
// Reset (rst, synchronous) clears all valid bits and loads step_length = 2.0 m
// and arrival_radius = 0.2 m; busy is high during reset and in the cycle after it.
// The receiver cannot stall: each result is shown for one cycle with done.
// ----------------------------------------------------------------------------
// waypoint_step_limiter
// Distance to a waypoint and one length-limited setpoint toward it.
// ----------------------------------------------------------------------------
`default_nettype none

module waypoint_step_limiter #(
  parameter int COORD_WIDTH = wsl_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = wsl_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [COORD_WIDTH-1:0]      pos_x,
  input  logic signed [COORD_WIDTH-1:0]      pos_y,
  input  logic signed [COORD_WIDTH-1:0]      pos_z,
  input  logic signed [COORD_WIDTH-1:0]      goal_x,
  input  logic signed [COORD_WIDTH-1:0]      goal_y,
  input  logic signed [COORD_WIDTH-1:0]      goal_z,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [wsl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wsl_pkg::CFG_W-1:0]          cfg_data,
  output logic                               done,
  output logic                               reached,
  output logic                               setpoint_valid,
  output logic signed [COORD_WIDTH-1:0]      set_x,
  output logic signed [COORD_WIDTH-1:0]      set_y,
  output logic signed [COORD_WIDTH-1:0]      set_z,
  output logic [COORD_WIDTH-1:0]             distance
);

  import wsl_pkg::*;

  `include "assert_macros.svh"

  localparam int CW     = COORD_WIDTH;
  localparam int SUM_W  = 2 * CW + 2;
  localparam int RAD_W  = (SUM_W > 64) ? 64 : SUM_W;
  localparam int ROOT_W = RAD_W / 2;
  localparam int NUM_W  = CW + CFG_W + 1;
  localparam int SIDE_A = 9 * CW + 3;
  localparam int SIDE_B = 7 * CW + 5;
  localparam int SW     = ((CW > CFG_W) ? CW : CFG_W) + 2;
  localparam int DC_W   = (ROOT_W > CFG_W) ? ROOT_W : CFG_W;
  localparam int LAT    = ROOT_W + CFG_W + 7;

  localparam logic [CFG_W-1:0] STEP_RST =
    CFG_W'(RESET_STEP_M * (1 << FRAC_BITS));
  localparam logic [CFG_W-1:0] RADIUS_RST =
    CFG_W'((RESET_RADIUS_NUM * (1 << FRAC_BITS)) / RESET_RADIUS_DEN);
  localparam logic [SUM_W-1:0] RAD_MAX = SUM_W'({RAD_W{1'b1}});
  localparam logic [ROOT_W-1:0] DIST_MAX = ROOT_W'({CW{1'b1}});
  localparam logic signed [SW-1:0] HI = (SW'(1) << (CW - 1)) - SW'(1);
  localparam logic signed [SW-1:0] LO = -HI - SW'(1);

  logic [CFG_W-1:0] step_length;
  logic [CFG_W-1:0] arrival_radius;
  logic             accept;

  // busy is a registered copy of rst: the pipeline takes a word every cycle while busy is low
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  assign accept    = start && !busy;
  assign cfg_ready = !busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      step_length    <= STEP_RST;
      arrival_radius <= RADIUS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_STEP_LENGTH:    step_length    <= cfg_data;
        REG_ARRIVAL_RADIUS: arrival_radius <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 0: input registers
  logic                 v0;
  logic [2:0][CW-1:0]   pos0, goal0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= accept;
    end
    pos0  <= {pos_z, pos_y, pos_x};
    goal0 <= {goal_z, goal_y, goal_x};
  end

  // stage 1: saturated difference, sign and magnitude
  logic                 v1;
  logic [2:0][CW-1:0]   pos1, goal1, mag1;
  logic [2:0]           neg1;
  logic [2:0][CW-1:0]   dsat;

  always_comb begin
    logic [CW:0] dif;
    for (int i = 0; i < 3; i++) begin
      dif = {goal0[i][CW-1], goal0[i]} - {pos0[i][CW-1], pos0[i]};
      if (dif[CW] != dif[CW-1]) begin
        dsat[i] = dif[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      end else begin
        dsat[i] = dif[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= v0;
    end
    for (int i = 0; i < 3; i++) begin
      neg1[i] <= dsat[i][CW-1];
      mag1[i] <= dsat[i][CW-1] ? ~dsat[i] + CW'(1) : dsat[i];
    end
    pos1  <= pos0;
    goal1 <= goal0;
  end

  // stage 2: squares
  logic                   v2;
  logic [2:0][CW-1:0]     pos2, goal2, mag2;
  logic [2:0]             neg2;
  logic [2:0][2*CW-1:0]   sq2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    for (int i = 0; i < 3; i++) begin
      sq2[i] <= mag1[i] * mag1[i];
    end
    pos2  <= pos1;
    goal2 <= goal1;
    mag2  <= mag1;
    neg2  <= neg1;
  end

  // stage 3: sum of squares, clamped to the root's input width
  logic               v3;
  logic [RAD_W-1:0]   rad3;
  logic [SIDE_A-1:0]  side3;
  logic [SUM_W-1:0]   sum2;

  assign sum2 = SUM_W'(sq2[0]) + SUM_W'(sq2[1]) + SUM_W'(sq2[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    rad3  <= (sum2 > RAD_MAX) ? {RAD_W{1'b1}} : sum2[RAD_W-1:0];
    side3 <= {pos2, goal2, neg2, mag2};
  end

  // square root
  logic               vr;
  logic [ROOT_W-1:0]  root_r;
  logic [SIDE_A-1:0]  side_r;
  logic [2:0][CW-1:0] pos_r, goal_r, mag_r;
  logic [2:0]         neg_r;

  wsl_sqrt #(
    .RAD_W  (RAD_W),
    .SIDE_W (SIDE_A)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v3),
    .rad       (rad3),
    .side_in   (side3),
    .out_valid (vr),
    .root      (root_r),
    .side_out  (side_r)
  );

  assign {pos_r, goal_r, neg_r, mag_r} = side_r;

  // stage 4: thresholds and step products
  logic                        v4;
  logic [2:0][CW-1:0]          pos4, goal4;
  logic [2:0]                  neg4;
  logic                        reached4, goal_sel4;
  logic [CW-1:0]               dist4;
  logic [ROOT_W-1:0]           root4;
  logic [2:0][CW+CFG_W-1:0]    prod4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= vr;
    end
    reached4  <= DC_W'(root_r) < DC_W'(arrival_radius);
    goal_sel4 <= (DC_W'(root_r) < DC_W'(step_length)) || (root_r == '0);
    dist4     <= (root_r > DIST_MAX) ? {CW{1'b1}} : root_r[CW-1:0];
    for (int i = 0; i < 3; i++) begin
      prod4[i] <= mag_r[i] * step_length;
    end
    root4 <= root_r;
    pos4  <= pos_r;
    goal4 <= goal_r;
    neg4  <= neg_r;
  end

  // stage 5: rounding term added to the numerators
  logic                     v5;
  logic [2:0][NUM_W-1:0]    num5;
  logic [ROOT_W-1:0]        den5;
  logic [SIDE_B-1:0]        side5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
    for (int i = 0; i < 3; i++) begin
      num5[i] <= NUM_W'(prod4[i]) + NUM_W'(root4 >> 1);
    end
    den5  <= root4;
    side5 <= {pos4, goal4, neg4, reached4, goal_sel4, dist4};
  end

  // division by the distance
  logic                     vd;
  logic [2:0][CFG_W-1:0]    quo_d;
  logic [SIDE_B-1:0]        side_d;
  logic [2:0][CW-1:0]       pos_d, goal_d;
  logic [2:0]               neg_d;
  logic                     reached_d, goal_sel_d;
  logic [CW-1:0]            dist_d;

  wsl_div #(
    .NUM_W  (NUM_W),
    .DEN_W  (ROOT_W),
    .QW     (CFG_W),
    .SIDE_W (SIDE_B)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v5),
    .num       (num5),
    .den       (den5),
    .side_in   (side5),
    .out_valid (vd),
    .quo       (quo_d),
    .side_out  (side_d)
  );

  assign {pos_d, goal_d, neg_d, reached_d, goal_sel_d, dist_d} = side_d;

  // stage 6: signed offset, saturated sum and setpoint selection
  logic [2:0][CW-1:0] set6;

  always_comb begin
    logic signed [SW-1:0] ps;
    logic signed [SW-1:0] qe;
    logic signed [SW-1:0] s;
    logic [CW-1:0]        sat;
    for (int i = 0; i < 3; i++) begin
      ps = SW'($signed(pos_d[i]));
      qe = SW'(quo_d[i]);
      s  = ps + (neg_d[i] ? -qe : qe);
      if (s > HI) begin
        sat = HI[CW-1:0];
      end else if (s < LO) begin
        sat = LO[CW-1:0];
      end else begin
        sat = s[CW-1:0];
      end
      if (reached_d) begin
        set6[i] = '0;
      end else if (goal_sel_d) begin
        set6[i] = goal_d[i];
      end else begin
        set6[i] = sat;
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vd;
    end
    reached        <= reached_d;
    setpoint_valid <= !reached_d;
    set_x          <= set6[0];
    set_y          <= set6[1];
    set_z          <= set6[2];
    distance       <= dist_d;
  end

  // checks
  `ASSERT_IMP(a_flags_exclusive, done, reached != setpoint_valid,
              "reached and setpoint_valid must differ")
  `ASSERT_IMP(a_reached_zero, done && reached,
              set_x == '0 && set_y == '0 && set_z == '0,
              "reached word carries a nonzero setpoint")
  `ASSERT_IMP(a_latency, done, $past(start && !busy, LAT),
              "result word without a matching start")

endmodule

`default_nettype wire

@@ rtl/core/wsl_sqrt.sv @@
// ----------------------------------------------------------------------------
// wsl_sqrt
// Pipelined integer square root, one root bit per register stage, with a
// side word that travels alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module wsl_sqrt #(
  parameter int RAD_W  = 50,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [RAD_W-1:0]  rad,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [RAD_W/2-1:0] root,
  output logic [SIDE_W-1:0] side_out
);

  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 3;

  logic [ROOT_W:0]     v_q;
  logic [RAD_W-1:0]    rad_q  [ROOT_W+1];
  logic [REM_W-1:0]    rem_q  [ROOT_W+1];
  logic [ROOT_W-1:0]   root_q [ROOT_W+1];
  logic [SIDE_W-1:0]   side_q [ROOT_W+1];

  // stage 0 is the input
  assign v_q[0]    = in_valid;
  assign rad_q[0]  = rad;
  assign rem_q[0]  = '0;
  assign root_q[0] = '0;
  assign side_q[0] = side_in;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [REM_W-1:0] cat;
    logic [REM_W-1:0] sub_v;
    logic [REM_W-1:0] dif;
    logic             ge;

    // trial subtract of (root*4 + 1) from the remainder with two new bits
    always_comb begin
      cat   = {rem_q[k][REM_W-3:0], rad_q[k][RAD_W-1 -: 2]};
      sub_v = {1'b0, root_q[k], 2'b01};
      ge    = (cat >= sub_v);
      dif   = cat - sub_v;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k+1] <= 1'b0;
      end else begin
        v_q[k+1] <= v_q[k];
      end
      rad_q[k+1]  <= rad_q[k] << 2;
      rem_q[k+1]  <= ge ? dif : cat;
      root_q[k+1] <= {root_q[k][ROOT_W-2:0], ge};
      side_q[k+1] <= side_q[k];
    end
  end

  assign out_valid = v_q[ROOT_W];
  assign root      = root_q[ROOT_W];
  assign side_out  = side_q[ROOT_W];

endmodule

`default_nettype wire

@@ rtl/core/wsl_div.sv @@
// ----------------------------------------------------------------------------
// wsl_div
// Pipelined restoring divider for three lanes sharing one divisor, one
// quotient bit per register stage. The quotient must fit in QW bits.
// ----------------------------------------------------------------------------
`default_nettype none

module wsl_div #(
  parameter int NUM_W  = 45,
  parameter int DEN_W  = 25,
  parameter int QW     = wsl_pkg::CFG_W,
  parameter int SIDE_W = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [2:0][NUM_W-1:0]     num,
  input  logic [DEN_W-1:0]          den,
  input  logic [SIDE_W-1:0]         side_in,
  output logic                      out_valid,
  output logic [2:0][QW-1:0]        quo,
  output logic [SIDE_W-1:0]         side_out
);

  import wsl_pkg::*;

  localparam int CMP_W = (NUM_W > DEN_W + QW) ? NUM_W : DEN_W + QW;

  logic [QW:0]               v_q;
  logic [2:0][CMP_W-1:0]     rem_q  [QW+1];
  logic [2:0][QW-1:0]        quo_q  [QW+1];
  logic [DEN_W-1:0]          den_q  [QW+1];
  logic [SIDE_W-1:0]         side_q [QW+1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rem_q[0][i] = CMP_W'(num[i]);
    end
  end

  assign v_q[0]    = in_valid;
  assign quo_q[0]  = '0;
  assign den_q[0]  = den;
  assign side_q[0] = side_in;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int SH = QW - 1 - k;
    logic [CMP_W-1:0] dsh;
    logic [2:0]       ge;

    // compare each remainder against the shifted divisor
    always_comb begin
      dsh = CMP_W'(den_q[k]) << SH;
      for (int i = 0; i < 3; i++) begin
        ge[i] = (rem_q[k][i] >= dsh);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k+1] <= 1'b0;
      end else begin
        v_q[k+1] <= v_q[k];
      end
      for (int i = 0; i < 3; i++) begin
        rem_q[k+1][i] <= ge[i] ? rem_q[k][i] - dsh : rem_q[k][i];
        quo_q[k+1][i] <= {quo_q[k][i][QW-2:0], ge[i]};
      end
      den_q[k+1]  <= den_q[k];
      side_q[k+1] <= side_q[k];
    end
  end

  assign out_valid = v_q[QW];
  assign quo       = quo_q[QW];
  assign side_out  = side_q[QW];

endmodule

`default_nettype wire

@@ test/waypoint_step_limiter_test.sv @@
// ----------------------------------------------------------------------------
// waypoint_step_limiter_test
// Self-checking bench for the waypoint step limiter. Positions and targets go
// in through the start/busy handshake, and each result word marked by done is
// compared with a local prediction of distance, reached flag and setpoint.
// Register writes happen only with the pipeline drained.
// ----------------------------------------------------------------------------
`default_nettype none

module waypoint_step_limiter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import wsl_pkg::*;

  localparam int CW       = COORD_WIDTH_DEF;
  localparam int LATENCY  = CW + 28;
  localparam int LIMIT    = 400000;
  localparam longint CMAX = (64'sd1 <<< (CW - 1)) - 1;
  localparam longint CMIN = -(64'sd1 <<< (CW - 1));
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct {
    coord_t px, py, pz, gx, gy, gz;
  } waypoint_t;

  typedef struct {
    logic          reached;
    logic          sp_valid;
    coord_t        sx, sy, sz;
    logic [CW-1:0] dist_w;
  } setpoint_t;

  logic clk = 0, rst = 1, start = 0, busy;
  coord_t pos_x = '0, pos_y = '0, pos_z = '0, goal_x = '0, goal_y = '0, goal_z = '0;
  logic cfg_valid = 0, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic done, reached, setpoint_valid;
  coord_t set_x, set_y, set_z;
  logic [CW-1:0] distance;

  // local copy of the registers
  longint step_len = 8192;
  longint arr_rad  = 819;

  setpoint_t pending_setpoints[$];
  int errors = 0, words_sent = 0, words_checked = 0, cycles = 0;
  int gap_pct = 0;

  waypoint_step_limiter dut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic longint sat_coord(longint v);
    if (v > CMAX) return CMAX;
    if (v < CMIN) return CMIN;
    return v;
  endfunction

  function automatic longint floor_sqrt(longint s);
    longint r, t;
    r = 0;
    for (int b = 26; b >= 0; b--) begin
      t = r | (64'sd1 <<< b);
      if (t * t <= s) r = t;
    end
    return r;
  endfunction

  // distance, reached test and step-limited setpoint
  function automatic setpoint_t predict_setpoint(waypoint_t w);
    longint p[3], g[3], d[3], m[3], s[3];
    longint sum, root_v, q;
    setpoint_t r;
    p[0] = w.px; p[1] = w.py; p[2] = w.pz;
    g[0] = w.gx; g[1] = w.gy; g[2] = w.gz;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      d[i] = sat_coord(g[i] - p[i]);
      m[i] = (d[i] < 0) ? -d[i] : d[i];
      sum += m[i] * m[i];
      s[i] = 0;
    end
    root_v = floor_sqrt(sum);
    r.dist_w = (root_v > (64'sd1 <<< CW) - 1) ? '1 : root_v[CW-1:0];
    r.reached = root_v < arr_rad;
    r.sp_valid = !r.reached;
    if (!r.reached) begin
      for (int i = 0; i < 3; i++) begin
        if (root_v < step_len || root_v == 0) begin
          s[i] = g[i];
        end else begin
          q = (m[i] * step_len + (root_v >> 1)) / root_v;
          s[i] = sat_coord(p[i] + ((d[i] < 0) ? -q : q));
        end
      end
    end
    r.sx = coord_t'(s[0]); r.sy = coord_t'(s[1]); r.sz = coord_t'(s[2]);
    return r;
  endfunction

  // result checker: done words against the oldest prediction
  always @(posedge clk) begin
    setpoint_t e;
    if (!rst && done) begin
      if (pending_setpoints.size() == 0) begin
        $error("result word with nothing pending");
        errors++;
      end else begin
        e = pending_setpoints.pop_front();
        words_checked++;
        if (reached !== e.reached) begin
          $error("reached: expected %0d, got %0d", e.reached, reached); errors++;
        end
        if (setpoint_valid !== e.sp_valid) begin
          $error("setpoint_valid: expected %0d, got %0d", e.sp_valid, setpoint_valid);
          errors++;
        end
        if (set_x !== e.sx) begin
          $error("set_x: expected %0d, got %0d", e.sx, set_x); errors++;
        end
        if (set_y !== e.sy) begin
          $error("set_y: expected %0d, got %0d", e.sy, set_y); errors++;
        end
        if (set_z !== e.sz) begin
          $error("set_z: expected %0d, got %0d", e.sz, set_z); errors++;
        end
        if (distance !== e.dist_w) begin
          $error("distance: expected %0d, got %0d", e.dist_w, distance); errors++;
        end
      end
    end
  end

  // send one word; then idle cycle by cycle with the gap probability
  task automatic send_waypoint(waypoint_t w);
    start  <= 1'b1;
    pos_x  <= w.px; pos_y  <= w.py; pos_z  <= w.pz;
    goal_x <= w.gx; goal_y <= w.gy; goal_z <= w.gz;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_setpoints = {pending_setpoints, predict_setpoint(w)};
    words_sent++;
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // stop sending and wait for every pending result
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_setpoints.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_STEP_LENGTH) step_len = val;
    else if (idx == REG_ARRIVAL_RADIUS) arr_rad = val;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic waypoint_t offset_waypoint(longint px, longint py, longint pz,
                                                longint dx, longint dy, longint dz);
    waypoint_t w;
    w.px = coord_t'(px); w.py = coord_t'(py); w.pz = coord_t'(pz);
    w.gx = coord_t'(sat_coord(px + dx));
    w.gy = coord_t'(sat_coord(py + dy));
    w.gz = coord_t'(sat_coord(pz + dz));
    return w;
  endfunction

  function automatic longint rand_delta(longint span);
    return longint'($urandom_range(int'(2 * span))) - span;
  endfunction

  // mostly targets near the step and arrival thresholds, some wide and extreme
  function automatic waypoint_t random_waypoint();
    waypoint_t w;
    longint span;
    int mode;
    mode = $urandom_range(99);
    w.px = coord_t'($urandom); w.py = coord_t'($urandom); w.pz = coord_t'($urandom);
    w.gx = coord_t'($urandom); w.gy = coord_t'($urandom); w.gz = coord_t'($urandom);
    if (mode < 45) begin
      span = 2 * step_len + 16;
      if (span > (64'sd1 <<< 22)) span = 64'sd1 <<< 22;
      w = offset_waypoint(w.px, w.py, w.pz,
                          rand_delta(span), rand_delta(span), rand_delta(span));
    end else if (mode < 65) begin
      span = arr_rad + 8;
      if (span > (64'sd1 <<< 22)) span = 64'sd1 <<< 22;
      w = offset_waypoint(w.px, w.py, w.pz,
                          rand_delta(span), rand_delta(span), rand_delta(span));
    end else if (mode < 80) begin
      w.px = coord_t'($urandom_range(1) ? CMAX : CMIN);
      w.gz = coord_t'($urandom_range(1) ? CMAX : CMIN);
    end
    return w;
  endfunction

  // extremes and threshold edges under the reset registers
  task automatic test_directed_defaults();
    send_waypoint(offset_waypoint(0, 0, 0, 0, 0, 0));
    send_waypoint(offset_waypoint(CMIN, CMIN, CMIN, -2 * CMIN, -2 * CMIN, -2 * CMIN));
    send_waypoint(offset_waypoint(CMAX, CMAX, CMAX, -2 * CMAX, -2 * CMAX, -2 * CMAX));
    send_waypoint(offset_waypoint(100, -200, 300, 819, 0, 0));
    send_waypoint(offset_waypoint(100, -200, 300, 0, -818, 0));
    send_waypoint(offset_waypoint(-5000, 7, 9, 0, 0, 8192));
    send_waypoint(offset_waypoint(0, 0, 0, 3 * 4096, 4 * 4096, 0));
    send_waypoint(offset_waypoint(4096, 4096, -4096, -3000, -40000, 12345));
    send_waypoint(offset_waypoint(CMAX, CMIN, 0, -1, 1, 0));
    send_waypoint(offset_waypoint(CMIN, CMAX, CMAX, 20000, -20000, -1));
    drain();
  endtask

  // zero radius, zero step and ignored register indexes
  task automatic test_special_registers();
    write_reg(REG_ARRIVAL_RADIUS, '0);
    send_waypoint(offset_waypoint(123, -456, 789, 0, 0, 0));
    send_waypoint(offset_waypoint(0, 0, 0, 1, 0, 0));
    write_reg(REG_STEP_LENGTH, '0);
    send_waypoint(offset_waypoint(1000, 2000, 3000, 50000, -60000, 70000));
    send_waypoint(offset_waypoint(CMIN, 0, CMAX, -2 * CMIN, 0, -2 * CMAX));
    write_reg(REG_SPARE_A, 20'h00005);
    write_reg(REG_SPARE_B, '1);
    send_waypoint(offset_waypoint(1000, 2000, 3000, 50000, -60000, 70000));
    write_reg(REG_STEP_LENGTH, 20'd1);
    send_waypoint(offset_waypoint(1000, 2000, 3000, 50000, -60000, 70000));
    write_reg(REG_STEP_LENGTH, '1);
    write_reg(REG_ARRIVAL_RADIUS, '1);
    send_waypoint(offset_waypoint(0, 0, 0, 1048574, 0, 0));
    send_waypoint(offset_waypoint(0, 0, 0, 1048575, 0, 0));
    send_waypoint(offset_waypoint(CMAX, CMAX, CMAX, -2 * CMAX, -2 * CMAX, -2 * CMAX));
    drain();
  endtask

  task automatic test_random(int count, int idle_pct);
    gap_pct = idle_pct;
    for (int i = 0; i < count; i++) begin
      send_waypoint(random_waypoint());
      // sender holds off once until the pipeline has emptied
      if (i == count / 2) drain();
    end
    drain();
  endtask

  task automatic test_register_sweep();
    write_reg(REG_STEP_LENGTH, 20'd8192);
    write_reg(REG_ARRIVAL_RADIUS, 20'd819);
    test_random(300, 12);
    write_reg(REG_STEP_LENGTH, 20'd1);
    write_reg(REG_ARRIVAL_RADIUS, '0);
    test_random(150, 77);
    write_reg(REG_STEP_LENGTH, '1);
    write_reg(REG_ARRIVAL_RADIUS, 20'd4096);
    test_random(150, 77);
    write_reg(REG_STEP_LENGTH, CFG_W'($urandom_range(1, 200000)));
    write_reg(REG_ARRIVAL_RADIUS, CFG_W'($urandom_range(0, 20000)));
    test_random(250, 0);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_defaults();
    test_special_registers();
    test_register_sweep();
    repeat (LATENCY + 20) @(posedge clk);
    $display("covered %0d words, %0d results checked, over reset, extreme and random",
             words_sent, words_checked);
    $display("register settings with sender gaps of 12, 77 and 0 percent");
    if (errors == 0 && pending_setpoints.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+rtl/core
rtl/core/wsl_pkg.sv
rtl/core/wsl_sqrt.sv
rtl/core/wsl_div.sv
rtl/core/waypoint_step_limiter.sv
test/waypoint_step_limiter_test.sv
